@@ rtl/heading_error_steer_core_macros.svh @@
// assertion helpers for the steering core
`ifndef HEADING_ERROR_STEER_CORE_MACROS_SVH
`define HEADING_ERROR_STEER_CORE_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define HES_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define HES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/hes_pkg.sv @@
package hes_pkg;

    localparam int TURN_UNITS    = 23040;
    localparam int ATAN_ENTRIES  = 24;
    localparam int SINE_ITER_DEF = 16;
    localparam int CW_RESET      = 16384;
    localparam int DIV_STEPS     = 16;

    typedef logic signed [16:0] t_diff;
    typedef logic signed [15:0] t_q15;

    // quadrant codes
    localparam logic [1:0] QUAD_Y     = 2'd0;
    localparam logic [1:0] QUAD_X     = 2'd1;
    localparam logic [1:0] QUAD_NEG_Y = 2'd2;
    localparam logic [1:0] QUAD_NEG_X = 2'd3;

    // arctangent table, units of 2^-32 turn
    function automatic logic [29:0] atan_lut(input int idx);
        logic [29:0] r;
        r = 30'd0;
        unique case (idx)
            0:  r = 30'd536870912;
            1:  r = 30'd316933406;
            2:  r = 30'd167458907;
            3:  r = 30'd85004756;
            4:  r = 30'd42667331;
            5:  r = 30'd21354465;
            6:  r = 30'd10679838;
            7:  r = 30'd5340245;
            8:  r = 30'd2670163;
            9:  r = 30'd1335087;
            10: r = 30'd667544;
            11: r = 30'd333772;
            12: r = 30'd166886;
            13: r = 30'd83443;
            14: r = 30'd41722;
            15: r = 30'd20861;
            16: r = 30'd10430;
            17: r = 30'd5215;
            18: r = 30'd2608;
            19: r = 30'd1304;
            20: r = 30'd652;
            21: r = 30'd326;
            22: r = 30'd163;
            23: r = 30'd81;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/hes_angle.sv @@
// difference, reduction to one turn and conversion to binary angle
module hes_angle (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [15:0]   i_heading,
    input  logic signed [15:0]   i_target,
    output logic                 o_valid,
    output hes_pkg::t_diff       o_diff,
    output logic [31:0]          o_bangle
);
    import hes_pkg::*;

    logic          r_v1, r_v2, r_v3;
    t_diff         r_d1, r_d2, r_d3;
    logic [14:0]   r_m;
    logic [31:0]   r_u;
    t_diff         n_d;
    logic signed [18:0] n_m;
    logic [14:0]   n_mr;

    // stage 1: difference
    assign n_d = t_diff'(i_target) - t_diff'(i_heading);

    // stage 2: modulo one turn (|d| < 3 turns, so one offset picked by range)
    always_comb begin
        priority if (r_d1 < -17'sd46080) n_m = 19'(r_d1) + 19'sd69120;
        else if (r_d1 < -17'sd23040)      n_m = 19'(r_d1) + 19'sd46080;
        else if (r_d1 < 17'sd0)           n_m = 19'(r_d1) + 19'sd23040;
        else if (r_d1 < 17'sd23040)       n_m = 19'(r_d1);
        else if (r_d1 < 17'sd46080)       n_m = 19'(r_d1) - 19'sd23040;
        else                              n_m = 19'(r_d1) - 19'sd46080;
        n_mr = n_m[14:0];
    end

    // valids travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; o_valid <= 1'b0;
        end else begin
            r_v1 <= i_valid; r_v2 <= r_v1; r_v3 <= r_v2; o_valid <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d1   <= n_d;
        r_m    <= n_mr;
        r_d2   <= r_d1;
        r_d3   <= r_d2;
        o_diff <= r_d3;
    end

    // quotient: q = floor((m*2^23 + 22)/45) with m < 23040
    // q = m*186413 + floor((m*23 + 22)/45) since 2^23 = 45*186413 + 23
    logic [14:0] r_m2;
    logic [19:0] r_small;
    always_ff @(posedge i_clk) begin
        r_m2    <= r_m;
        r_small <= 20'(r_m) * 20'd23 + 20'd22;
    end

    // small quotient by reciprocal ceil(2^25/45), exact for inputs below 780336
    logic [31:0] n_u;
    logic [31:0] n_hi;
    logic [19:0] n_lo;
    always_comb begin
        n_hi = 32'(r_m2) * 32'd186413;
        n_lo = 20'((40'(r_small) * 40'd745655) >> 25);
        n_u  = n_hi + 32'(n_lo);
    end
    always_ff @(posedge i_clk) r_u <= n_u;

    assign o_bangle = r_u;
endmodule

@@ rtl/hes_cordic.sv @@
// pipelined rotation cordic, one stage per iteration
module hes_cordic #(
    parameter int SINE_ITERATIONS = hes_pkg::SINE_ITER_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [31:0]          i_bangle,
    output logic                 o_valid,
    output hes_pkg::t_q15        o_sine
);
    import hes_pkg::*;

    localparam int N = (SINE_ITERATIONS < ATAN_ENTRIES) ? SINE_ITERATIONS : ATAN_ENTRIES;

    logic               r_v [N+1];
    logic signed [33:0] r_x [N+1];
    logic signed [33:0] r_y [N+1];
    logic signed [32:0] r_z [N+1];
    logic [1:0]         r_q [N+1];

    always_comb begin
        r_v[0] = i_valid;
        r_x[0] = 34'sd652032874;
        r_y[0] = 34'sd0;
        r_z[0] = 33'($signed({1'b0, i_bangle[29:0]}));
        r_q[0] = i_bangle[31:30];
    end

    // one rotation per register stage
    for (genvar i = 0; i < N; i++) begin : g_stage
        logic signed [33:0] dx, dy;
        assign dx = r_y[i] >>> i;
        assign dy = r_x[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[i+1] <= 1'b0;
            else          r_v[i+1] <= r_v[i];
        end
        always_ff @(posedge i_clk) begin
            r_q[i+1] <= r_q[i];
            if (!r_z[i][32]) begin
                r_x[i+1] <= r_x[i] - dx;
                r_y[i+1] <= r_y[i] + dy;
                r_z[i+1] <= r_z[i] - 33'(atan_lut(i));
            end else begin
                r_x[i+1] <= r_x[i] + dx;
                r_y[i+1] <= r_y[i] - dy;
                r_z[i+1] <= r_z[i] + 33'(atan_lut(i));
            end
        end
    end

    // quadrant select, rounding and saturation
    logic signed [34:0] n_s;
    logic signed [19:0] n_r;
    always_comb begin
        unique case (r_q[N])
            QUAD_Y:     n_s = 35'(r_y[N]);
            QUAD_X:     n_s = 35'(r_x[N]);
            QUAD_NEG_Y: n_s = -35'(r_y[N]);
            QUAD_NEG_X: n_s = -35'(r_x[N]);
            default:    n_s = 35'sd0;
        endcase
        n_r = 20'((n_s + 35'sd16384) >>> 15);
        if (n_r > 20'sd32767)  n_r = 20'sd32767;
        if (n_r < -20'sd32767) n_r = -20'sd32767;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= r_v[N];
        o_sine <= n_r[15:0];
    end
endmodule

@@ rtl/hes_divide.sv @@
// saturation clamp and pipelined restoring divide, one quotient bit per stage
module hes_divide (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  hes_pkg::t_q15        i_factor,
    input  logic [14:0]          i_width,
    input  hes_pkg::t_diff       i_diff,
    output logic                 o_valid,
    output hes_pkg::t_diff       o_diff,
    output hes_pkg::t_q15        o_factor,
    output hes_pkg::t_q15        o_cmd
);
    import hes_pkg::*;

    localparam int S = DIV_STEPS;

    logic        r_v   [S+1];
    logic        r_sat [S+1];
    logic        r_neg [S+1];
    logic [14:0] r_w   [S+1];
    logic [15:0] r_rem [S+1];
    logic [29:0] r_num [S+1];
    logic [15:0] r_q   [S+1];
    t_diff       r_d   [S+1];
    t_q15        r_f   [S+1];

    logic [14:0] n_mag;
    assign n_mag = i_factor[15] ? 15'(-i_factor) : i_factor[14:0];

    // the upper mag bits are already below w, so they start as the remainder
    always_comb begin
        r_v[0]   = i_valid;
        r_sat[0] = (n_mag >= i_width);
        r_neg[0] = i_factor[15];
        r_w[0]   = i_width;
        r_rem[0] = {2'b0, n_mag[14:1]};
        r_num[0] = {n_mag[0], 29'd0};
        r_q[0]   = 16'd0;
        r_d[0]   = i_diff;
        r_f[0]   = i_factor;
    end

    // mag*32768 / w: last mag bit then 15 zero bits, 16 quotient bits
    for (genvar i = 0; i < S; i++) begin : g_div
        logic [16:0] t;
        assign t = {r_rem[i], r_num[i][29]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[i+1] <= 1'b0;
            else          r_v[i+1] <= r_v[i];
        end
        always_ff @(posedge i_clk) begin
            r_sat[i+1] <= r_sat[i];
            r_neg[i+1] <= r_neg[i];
            r_w[i+1]   <= r_w[i];
            r_d[i+1]   <= r_d[i];
            r_f[i+1]   <= r_f[i];
            r_num[i+1] <= {r_num[i][28:0], 1'b0};
            if (t >= {2'b0, r_w[i]}) begin
                r_rem[i+1] <= 16'(t - {2'b0, r_w[i]});
                r_q[i+1]   <= {r_q[i][14:0], 1'b1};
            end else begin
                r_rem[i+1] <= t[15:0];
                r_q[i+1]   <= {r_q[i][14:0], 1'b0};
            end
        end
    end

    // sign and saturation of the command
    logic [15:0] n_q;
    t_q15        n_cmd;
    always_comb begin
        n_q = (r_q[S] > 16'd32767) ? 16'd32767 : r_q[S];
        if (r_sat[S])      n_cmd = r_neg[S] ? -16'sd32767 : 16'sd32767;
        else if (r_neg[S]) n_cmd = -$signed(n_q);
        else               n_cmd = $signed(n_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= r_v[S];
        o_diff   <= r_d[S];
        o_factor <= r_f[S];
        o_cmd    <= n_cmd;
    end
endmodule

@@ rtl/heading_error_steer_core.sv @@
// channel   | dir | signals
// command   | in  | i_start, o_busy, i_heading, i_target_heading
// config    | in  | i_cfg_we, i_cfg_wdata (centre width)
// result    | out | o_done, o_heading_delta, o_sine_factor, o_steer_command
//
// one pair accepted every cycle; o_busy only during reset
// a pair passes through the angle, cordic and divider pipelines in that order
// synchronous active-low reset clears valids and sets centre width to 16384
// the receiver cannot stall; each result strobes o_done for one cycle
module heading_error_steer_core #(
    parameter int SINE_ITERATIONS = hes_pkg::SINE_ITER_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic signed [15:0]   i_heading,
    input  logic signed [15:0]   i_target_heading,
    input  logic                 i_cfg_we,
    input  logic [14:0]          i_cfg_wdata,
    output logic                 o_done,
    output logic signed [16:0]   o_heading_delta,
    output logic signed [15:0]   o_sine_factor,
    output logic signed [15:0]   o_steer_command
);
    import hes_pkg::*;
    `include "heading_error_steer_core_macros.svh"

    localparam int N = (SINE_ITERATIONS < ATAN_ENTRIES) ? SINE_ITERATIONS : ATAN_ENTRIES;

    logic [14:0] r_centre_width;
    logic        a_v, c_v;
    t_diff       a_d;
    logic [31:0] a_u;
    t_q15        c_s;
    t_diff       r_dq [N+2];

    assign o_busy = !i_rst_n;

    // config register transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_centre_width <= 15'(CW_RESET);
        else if (i_cfg_we) r_centre_width <= i_cfg_wdata;
    end

    hes_angle u_angle (
        .i_clk, .i_rst_n, .i_valid(i_start && !o_busy),
        .i_heading, .i_target(i_target_heading),
        .o_valid(a_v), .o_diff(a_d), .o_bangle(a_u)
    );

    hes_cordic #(.SINE_ITERATIONS(SINE_ITERATIONS)) u_cordic (
        .i_clk, .i_rst_n, .i_valid(a_v), .i_bangle(a_u),
        .o_valid(c_v), .o_sine(c_s)
    );

    // carry difference alongside the cordic stages
    assign r_dq[0] = a_d;
    for (genvar k = 0; k < N + 1; k++) begin : g_dq
        always_ff @(posedge i_clk) r_dq[k+1] <= r_dq[k];
    end

    hes_divide u_div (
        .i_clk, .i_rst_n, .i_valid(c_v), .i_factor(c_s),
        .i_width(r_centre_width), .i_diff(r_dq[N+1]),
        .o_valid(o_done), .o_diff(o_heading_delta),
        .o_factor(o_sine_factor), .o_cmd(o_steer_command)
    );

    `HES_ASSERT_IMPL(a_cmd_range, o_done, o_steer_command != -16'sd32768, "cmd range")
    `HES_ASSERT_IMPL(a_tf_range, o_done, o_sine_factor != -16'sd32768, "factor range")
    `HES_ASSERT_IMPL(a_sign, o_done && o_sine_factor > 0, o_steer_command > 0, "sign mismatch")
endmodule

@@ tb/sv/tb_top.sv @@
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hes_pkg::*;

    localparam int ITERS = SINE_ITER_DEF;
    localparam int LATENCY = ITERS + 22;

    typedef struct packed {
        logic signed [15:0] heading;
        logic signed [15:0] target;
    } t_pair;

    typedef struct packed {
        t_diff diff;
        t_q15  factor;
        t_q15  command;
    } t_steer;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_start = 1'b0;
    logic                o_busy;
    logic signed [15:0]  i_heading = '0;
    logic signed [15:0]  i_target_heading = '0;
    logic                i_cfg_we = 1'b0;
    logic [14:0]         i_cfg_wdata = '0;
    logic                o_done;
    logic signed [16:0]  o_heading_delta;
    logic signed [15:0]  o_sine_factor;
    logic signed [15:0]  o_steer_command;

    heading_error_steer_core uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (i_start),
        .o_busy             (o_busy),
        .i_heading          (i_heading),
        .i_target_heading   (i_target_heading),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .o_done             (o_done),
        .o_heading_delta    (o_heading_delta),
        .o_sine_factor      (o_sine_factor),
        .o_steer_command    (o_steer_command)
    );

    always #5 i_clk = ~i_clk;

    t_pair  pending_pairs[$];
    t_steer expected_steer[$];
    int     width_model = CW_RESET;
    int     errors = 0;
    int     burst_left = 0;
    int     gap_left = 0;

    // floor shift of a signed value
    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    // cordic sine of a difference in 1/64 degree, q1.15
    function automatic int sine_of(int diff);
        int      m;
        longint  u, z, x, y, dx, dy, s;
        longint  atans[24];
        int      quad;
        atans = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                  10679838, 5340245, 2670163, 1335087, 667544, 333772,
                  166886, 83443, 41722, 20861, 10430, 5215,
                  2608, 1304, 652, 326, 163, 81};
        m = diff % TURN_UNITS;
        if (m < 0) m += TURN_UNITS;
        u = ((longint'(m) << 23) + 22) / 45;
        quad = int'(u >> 30) & 3;
        z = u & 64'h3FFF_FFFF;
        x = 652032874;
        y = 0;
        for (int i = 0; i < ITERS && i < ATAN_ENTRIES; i++) begin
            dx = fshift(y, i);
            dy = fshift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atans[i];
            end else begin
                x += dx; y -= dy; z += atans[i];
            end
        end
        case (quad[1:0])
            QUAD_Y:     s = y;
            QUAD_X:     s = x;
            QUAD_NEG_Y: s = -y;
            default:    s = -x;
        endcase
        s = fshift(s + 16384, 15);
        if (s > 32767) s = 32767;
        if (s < -32767) s = -32767;
        return int'(s);
    endfunction

    // expected steering outputs for one pair
    function automatic t_steer steer_of(t_pair p);
        t_steer r;
        int     d, f, mag, cmd;
        d = int'(p.target) - int'(p.heading);
        f = sine_of(d);
        mag = f < 0 ? -f : f;
        if (mag >= width_model) begin
            cmd = f < 0 ? -32767 : 32767;
        end else begin
            cmd = (f * 32768) / width_model;
            if (cmd > 32767) cmd = 32767;
            if (cmd < -32767) cmd = -32767;
        end
        r.diff = t_diff'(d);
        r.factor = t_q15'(f);
        r.command = t_q15'(cmd);
        return r;
    endfunction

    // driver: bursty sender, prediction at each accepted transfer
    always @(posedge i_clk) begin
        t_pair p;
        if (i_rst_n && i_start && !o_busy) begin
            p = pending_pairs.pop_front();
            expected_steer.push_back(steer_of(p));
        end
        if (!i_rst_n || (i_start && o_busy)) begin
            // hold current state
        end else if (pending_pairs.size() > 0 && gap_left == 0) begin
            i_start <= 1'b1;
            i_heading <= pending_pairs[0].heading;
            i_target_heading <= pending_pairs[0].target;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 40);
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            i_start <= 1'b0;
            if (gap_left > 0) gap_left <= gap_left - 1;
        end
    end

    // monitor: compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_steer e;
        if (i_rst_n && o_done) begin
            if (expected_steer.size() == 0) begin
                $display("%0t unexpected result diff=%0d factor=%0d cmd=%0d", $time,
                         o_heading_delta, o_sine_factor, o_steer_command);
                errors++;
            end else begin
                e = expected_steer.pop_front();
                if (o_heading_delta !== e.diff) begin
                    $display("%0t heading_delta exp %0d got %0d", $time,
                             e.diff, o_heading_delta);
                    errors++;
                end
                if (o_sine_factor !== e.factor) begin
                    $display("%0t sine_factor exp %0d got %0d", $time,
                             e.factor, o_sine_factor);
                    errors++;
                end
                if (o_steer_command !== e.command) begin
                    $display("%0t steer_command exp %0d got %0d", $time,
                             e.command, o_steer_command);
                    errors++;
                end
            end
        end
    end

    task automatic queue_pair(int h, int t);
        t_pair p;
        p.heading = 16'(h);
        p.target = 16'(t);
        pending_pairs.push_back(p);
    endtask

    // wait until every queued pair has been transferred and answered
    task automatic drain();
        while (pending_pairs.size() > 0 || expected_steer.size() > 0 || i_start)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_width(int w);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= 15'(w);
        width_model = w;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int n);
        int h, d;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: queue_pair($urandom_range(0, 65535), $urandom_range(0, 65535));
                1: begin
                    // small errors around the saturation threshold
                    h = $urandom_range(0, 65535);
                    d = $urandom_range(0, 4000) - 2000;
                    queue_pair(h, h + d);
                end
                2: begin
                    // near quadrant edges of a turn
                    h = $urandom_range(0, 65535);
                    d = 5760 * $urandom_range(0, 8) - 23040 + $urandom_range(0, 8) - 4;
                    queue_pair(h, h + d);
                end
                default: queue_pair(int'($urandom) & 32'hFFFF, int'($urandom) & 32'hFFFF);
            endcase
        end
    endtask

    initial begin
        int widths[6];
        widths = '{0, 1, 32767, 8192, 30000, 0};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, zero and full turns, quadrant points
        queue_pair(-32768, 32767);
        queue_pair(32767, -32768);
        queue_pair(0, 0);
        queue_pair(-32768, -32768);
        queue_pair(0, 5760);
        queue_pair(0, -5760);
        queue_pair(0, 11520);
        queue_pair(0, 23040);
        queue_pair(0, -23040);
        queue_pair(100, 17380);
        queue_pair(0, 1);
        queue_pair(0, -1);
        queue_pair(0, 1920);
        queue_pair(0, -1920);
        queue_pair(-1920, 0);
        queue_pair(32767, 32767 - 5760);
        queue_pair(-12345, 12345);
        queue_pair(0, 46080 - 65536);
        drain();

        // reset width, then several settings including the extremes
        random_phase(300);
        drain();
        foreach (widths[k]) begin
            write_width(widths[k] == 0 && k == 5 ? $urandom_range(1, 32767) : widths[k]);
            queue_pair(0, 0);
            queue_pair(0, 1920);
            queue_pair(0, -1920);
            random_phase(k == 5 ? 250 : 200);
            drain();
        end

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #2ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+rtl
rtl/hes_pkg.sv
rtl/hes_angle.sv
rtl/hes_cordic.sv
rtl/hes_divide.sv
rtl/heading_error_steer_core.sv
tb/sv/tb_top.sv
